// ===== design/pslex_pkg.sv =====
`default_nettype none

package pslex_pkg;

  localparam int KW_NUM = 17;
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam logic [5:0] K_IDENT  = 6'd0;
  localparam logic [5:0] K_INT    = 6'd1;
  localparam logic [5:0] K_REAL   = 6'd2;
  localparam logic [5:0] K_KW0    = 6'd3;
  localparam logic [5:0] K_RBRACE = 6'd20;
  localparam logic [5:0] K_ASSIGN = 6'd21;
  localparam logic [5:0] K_NE     = 6'd22;
  localparam logic [5:0] K_GE     = 6'd23;
  localparam logic [5:0] K_LE     = 6'd24;
  localparam logic [5:0] K_LT     = 6'd25;
  localparam logic [5:0] K_GT     = 6'd26;
  localparam logic [5:0] K_EQ     = 6'd27;
  localparam logic [5:0] K_COLON  = 6'd28;
  localparam logic [5:0] K_SEMI   = 6'd29;
  localparam logic [5:0] K_DOT    = 6'd30;
  localparam logic [5:0] K_PLUS   = 6'd31;
  localparam logic [5:0] K_MINUS  = 6'd32;
  localparam logic [5:0] K_SLASH  = 6'd33;
  localparam logic [5:0] K_STAR   = 6'd34;
  localparam logic [5:0] K_LPAREN = 6'd35;
  localparam logic [5:0] K_RPAREN = 6'd36;
  localparam logic [5:0] K_BADCH  = 6'd37;
  localparam logic [5:0] K_BADCOM = 6'd38;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [5:0] kind;
    logic [6:0] len;
    logic [7:0] bad;
  } tok_t;

  typedef struct packed {
    tok_t tok0;
    tok_t tok1;
    logic two;
  } rec_t;

  function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [3:0] pos);
    logic [79:0] s;
    logic [79:0] sh;
    unique case (idx)
      5'd0:    s = "program   ";
      5'd1:    s = "begin     ";
      5'd2:    s = "end       ";
      5'd3:    s = "var       ";
      5'd4:    s = "procedure ";
      5'd5:    s = "const     ";
      5'd6:    s = "integer   ";
      5'd7:    s = "real      ";
      5'd8:    s = "if        ";
      5'd9:    s = "else      ";
      5'd10:   s = "then      ";
      5'd11:   s = "read      ";
      5'd12:   s = "write     ";
      5'd13:   s = "while     ";
      5'd14:   s = "do        ";
      5'd15:   s = "for       ";
      5'd16:   s = "to        ";
      default: s = '0;
    endcase
    sh = s << {pos, 3'b000};
    return sh[79:72];
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] idx);
    logic [3:0] l;
    unique case (idx) inside
      5'd0, 5'd6:                          l = 4'd7;
      5'd1, 5'd5, 5'd12, 5'd13:            l = 4'd5;
      5'd2, 5'd3, 5'd15:                   l = 4'd3;
      5'd4:                                l = 4'd9;
      5'd7, 5'd9, 5'd10, 5'd11:            l = 4'd4;
      5'd8, 5'd14, 5'd16:                  l = 4'd2;
      default:                             l = 4'd0;
    endcase
    return l;
  endfunction

  // bit 6 flags a single-character symbol
  function automatic logic [6:0] sym_kind(input logic [7:0] c);
    logic [6:0] r;
    unique case (c)
      CH_RBRACE: r = {1'b1, K_RBRACE};
      CH_EQ:     r = {1'b1, K_EQ};
      8'h3B:     r = {1'b1, K_SEMI};
      CH_DOT:    r = {1'b1, K_DOT};
      8'h2B:     r = {1'b1, K_PLUS};
      8'h2D:     r = {1'b1, K_MINUS};
      8'h2F:     r = {1'b1, K_SLASH};
      8'h2A:     r = {1'b1, K_STAR};
      8'h28:     r = {1'b1, K_LPAREN};
      8'h29:     r = {1'b1, K_RPAREN};
      default:   r = {1'b0, K_BADCH};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/pslex_front.sv =====
`default_nettype none

module pslex_front #(
  parameter int MAX_TOKEN = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 stall_o,
  input  wire logic [7:0]      char_i,
  input  wire logic            eoi_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output pslex_pkg::rec_t      rec_o
);
  import pslex_pkg::*;

  localparam int CntW = $clog2(MAX_TOKEN + 1);

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_IDENT   = 3'd1;
  localparam logic [2:0] M_INT     = 3'd2;
  localparam logic [2:0] M_REAL    = 3'd3;
  localparam logic [2:0] M_LESS    = 3'd4;
  localparam logic [2:0] M_GREATER = 3'd5;
  localparam logic [2:0] M_COLON   = 3'd6;
  localparam logic [2:0] M_COMMENT = 3'd7;

  logic [2:0]        mode_q, mode_d;
  logic [CntW-1:0]   cnt_q, cnt_d, cnt_inc;
  logic [KW_NUM-1:0] hits_q, hits_d, match, match0;
  logic              accept;
  logic              is_digit, is_letter, is_blank;
  logic [6:0]        sym;
  logic [15:0]       cnt_wide;
  logic [6:0]        len_sat;
  logic [5:0]        ident_kind;
  tok_t              mode_tok, t0, idle_tok;
  logic              t0_v, do_idle, idle_v;
  logic [2:0]        idle_mode;
  logic [CntW-1:0]   idle_cnt;
  logic [KW_NUM-1:0] idle_hits;

  assign accept  = valid_i && !full_i;
  assign stall_o = full_i;

  assign is_digit  = (char_i >= 8'h30) && (char_i <= 8'h39);
  assign is_letter = ((char_i >= 8'h41) && (char_i <= 8'h5A)) ||
                     ((char_i >= 8'h61) && (char_i <= 8'h7A));
  assign is_blank  = (char_i == CH_SPACE) || (char_i == CH_TAB) || (char_i == CH_LF) ||
                     (char_i == CH_CR) || (char_i == CH_NUL);
  assign sym       = sym_kind(char_i);

  assign cnt_inc  = (cnt_q < CntW'(MAX_TOKEN)) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_wide = 16'(cnt_q);
  assign len_sat  = (cnt_wide > 16'd127) ? 7'd127 : cnt_wide[6:0];

  always_comb begin
    for (int k = 0; k < KW_NUM; k++) begin
      match[k]  = (cnt_q < CntW'(kw_len(5'(k)))) && (kw_char(5'(k), cnt_q[3:0]) == char_i);
      match0[k] = (kw_char(5'(k), 4'd0) == char_i);
    end
  end

  always_comb begin
    ident_kind = K_IDENT;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (hits_q[k] && (cnt_q == CntW'(kw_len(5'(k))))) begin
        ident_kind = 6'(K_KW0 + 6'(k));
      end
    end
  end

  always_comb begin
    mode_tok = '{kind: K_IDENT, len: 7'd1, bad: 8'd0};
    unique case (mode_q)
      M_IDENT:   mode_tok = '{kind: ident_kind, len: len_sat, bad: 8'd0};
      M_INT:     mode_tok = '{kind: K_INT, len: len_sat, bad: 8'd0};
      M_REAL:    mode_tok = '{kind: K_REAL, len: len_sat, bad: 8'd0};
      M_LESS:    mode_tok = '{kind: K_LT, len: 7'd1, bad: 8'd0};
      M_GREATER: mode_tok = '{kind: K_GT, len: 7'd1, bad: 8'd0};
      M_COLON:   mode_tok = '{kind: K_COLON, len: 7'd1, bad: 8'd0};
      M_COMMENT: mode_tok = '{kind: K_BADCOM, len: len_sat, bad: 8'd0};
      default:   mode_tok = '{kind: K_IDENT, len: 7'd0, bad: 8'd0};
    endcase
  end

  // fresh scan of the character from idle
  always_comb begin
    idle_mode = M_IDLE;
    idle_cnt  = '0;
    idle_hits = '1;
    idle_v    = 1'b0;
    idle_tok  = '{kind: sym[5:0], len: 7'd1, bad: 8'd0};
    if (is_blank) begin
      idle_v = 1'b0;
    end else if (is_digit) begin
      idle_mode = M_INT;
      idle_cnt  = CntW'(1);
    end else if (is_letter) begin
      idle_mode = M_IDENT;
      idle_cnt  = CntW'(1);
      idle_hits = match0;
    end else if (char_i == CH_LT) begin
      idle_mode = M_LESS;
    end else if (char_i == CH_GT) begin
      idle_mode = M_GREATER;
    end else if (char_i == CH_COLON) begin
      idle_mode = M_COLON;
    end else if (char_i == CH_LBRACE) begin
      idle_mode = M_COMMENT;
      idle_cnt  = CntW'(1);
    end else if (sym[6]) begin
      idle_v = 1'b1;
    end else begin
      idle_v   = 1'b1;
      idle_tok = '{kind: K_BADCH, len: 7'd1, bad: char_i};
    end
  end

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    hits_d  = hits_q;
    t0_v    = 1'b0;
    t0      = mode_tok;
    do_idle = 1'b0;
    if (eoi_i) begin
      t0_v   = (mode_q != M_IDLE);
      mode_d = M_IDLE;
      cnt_d  = '0;
      hits_d = '1;
    end else begin
      unique case (mode_q) inside
        M_IDENT: begin
          if (is_letter || is_digit) begin
            hits_d = hits_q & match;
            cnt_d  = cnt_inc;
          end else begin
            t0_v    = 1'b1;
            do_idle = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit) begin
            cnt_d = cnt_inc;
          end else if (char_i == CH_DOT) begin
            cnt_d  = cnt_inc;
            mode_d = M_REAL;
          end else begin
            t0_v    = 1'b1;
            do_idle = 1'b1;
          end
        end
        M_REAL: begin
          if (is_digit) begin
            cnt_d = cnt_inc;
          end else begin
            t0_v    = 1'b1;
            do_idle = 1'b1;
          end
        end
        M_LESS, M_GREATER, M_COLON: begin
          t0_v = 1'b1;
          if ((char_i == CH_EQ) || ((mode_q == M_LESS) && (char_i == CH_GT))) begin
            mode_d = M_IDLE;
            cnt_d  = '0;
            hits_d = '1;
            if (mode_q == M_LESS) begin
              t0 = '{kind: (char_i == CH_EQ) ? K_LE : K_NE, len: 7'd2, bad: 8'd0};
            end else if (mode_q == M_GREATER) begin
              t0 = '{kind: K_GE, len: 7'd2, bad: 8'd0};
            end else begin
              t0 = '{kind: K_ASSIGN, len: 7'd2, bad: 8'd0};
            end
          end else begin
            do_idle = 1'b1;
          end
        end
        M_COMMENT: begin
          if (char_i == CH_LF) begin
            t0_v   = 1'b1;
            mode_d = M_IDLE;
            cnt_d  = '0;
            hits_d = '1;
          end else if (char_i == CH_RBRACE) begin
            mode_d = M_IDLE;
            cnt_d  = '0;
            hits_d = '1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
      if (do_idle) begin
        mode_d = idle_mode;
        cnt_d  = idle_cnt;
        hits_d = idle_hits;
      end
    end
  end

  assign push_o     = accept && (t0_v || (do_idle && idle_v));
  assign rec_o.tok0 = t0_v ? t0 : idle_tok;
  assign rec_o.tok1 = idle_tok;
  assign rec_o.two  = t0_v && do_idle && idle_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cnt_q  <= '0;
      hits_q <= '1;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      hits_q <= hits_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/pslex_queue.sv =====
`default_nettype none

module pslex_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire pslex_pkg::rec_t rec_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output pslex_pkg::rec_t      rec_o
);
  import pslex_pkg::*;

  rec_t               mem_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (Q_PTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Q_PTR_W + 1)'(QUEUE_DEPTH)) else $error("queue count out of range");
  a_cnt_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count lost a push");
`endif

endmodule

`default_nettype wire

// ===== design/pslex_back.sv =====
`default_nettype none

module pslex_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  input  wire pslex_pkg::rec_t rec_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [5:0]           token_kind_o,
  output logic [6:0]           lexeme_length_o,
  output logic [7:0]           bad_char_o,
  output logic                 last_of_run_o
);
  import pslex_pkg::*;

  logic out_v_q, sec_v_q, last_q;
  tok_t out_q, sec_q;
  logic load;

  assign load  = !out_v_q || !out_stall_i;
  assign pop_o = load && !sec_v_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sec_v_q <= 1'b0;
    end else if (load) begin
      if (sec_v_q) begin
        out_v_q <= 1'b1;
        sec_v_q <= 1'b0;
      end else begin
        out_v_q <= !empty_i;
        sec_v_q <= !empty_i && rec_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_v_q) begin
        out_q  <= sec_q;
        last_q <= 1'b1;
      end else begin
        out_q  <= rec_i.tok0;
        last_q <= !rec_i.two;
        sec_q  <= rec_i.tok1;
      end
    end
  end

  assign out_valid_o     = out_v_q;
  assign token_kind_o    = out_q.kind;
  assign lexeme_length_o = out_q.len;
  assign bad_char_o      = out_q.bad;
  assign last_of_run_o   = last_q;

`ifndef SYNTH
  a_sec_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_v_q |-> (out_v_q && !last_q)) else $error("second token without first");
  a_no_pop_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_v_q |-> !pop_o) else $error("pop while second token pending");
  a_sec_then_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sec_v_q && !out_stall_i) |=> (out_v_q && last_q)) else $error("second token not last");
`endif

endmodule

`default_nettype wire

// ===== design/pascal_subset_lexer.sv =====
// Channel | Handshake                   | Payload
// in      | in_valid_i / in_stall_o     | char_code_i, end_of_input_i
// out     | out_valid_o / out_stall_i   | token_kind_o, lexeme_length_o, bad_char_o,
//         |                             | last_of_run_o
//
// One character is accepted per cycle while in_stall_o is low; the scanner state updates in that cycle.
// Tokens leave one per cycle from a registered output stage while out_stall_i is low, so a
// character that closes one token and makes another leaves its two tokens one after the other.
// A four-entry token-record queue sits between scanner and output; in_stall_o is its full flag.
// A token passes from the scanner through the queue and the registered output stage to the outputs.
// Reset clears the scanner to idle and empties queue and output stage.
`default_nettype none

module pascal_subset_lexer #(
  parameter int MAX_TOKEN = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       end_of_input_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [5:0]      token_kind_o,
  output logic [6:0]      lexeme_length_o,
  output logic [7:0]      bad_char_o,
  output logic            last_of_run_o
);
  import pslex_pkg::*;

  logic push, full, pop, empty;
  rec_t rec_in, rec_out;

  pslex_front #(
    .MAX_TOKEN(MAX_TOKEN)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .char_i  (char_code_i),
    .eoi_i   (end_of_input_i),
    .full_i  (full),
    .push_o  (push),
    .rec_o   (rec_in)
  );

  pslex_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rec_o   (rec_out)
  );

  pslex_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .rec_i           (rec_out),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .token_kind_o    (token_kind_o),
    .lexeme_length_o (lexeme_length_o),
    .bad_char_o      (bad_char_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_pascal_subset_lexer.sv =====
`timescale 1ns / 1ps

import pslex_pkg::*;

typedef enum logic [2:0] {
  SC_IDLE, SC_IDENT, SC_INT, SC_REAL, SC_LESS, SC_GREATER, SC_COLON, SC_COMMENT
} scan_state_e;

typedef struct packed {
  logic [5:0] kind;
  logic [6:0] len;
  logic [7:0] bad;
  logic       last;
} token_t;

typedef struct packed {
  logic [7:0] c;
  logic       eoi;
} req_t;

class lex_scoreboard;
  scan_state_e  scan_state;
  int unsigned  lex_len;
  int unsigned  max_len;
  logic [16:0]  kw_live;
  string        kw_words[17];
  token_t       expected_tokens[$];
  int unsigned  requests;
  int unsigned  tokens;
  int unsigned  mismatches;
  int unsigned  saturated;
  logic [63:0]  kinds_seen;

  function new(int unsigned max_token);
    kw_words = '{"program", "begin", "end", "var", "procedure", "const", "integer",
                 "real", "if", "else", "then", "read", "write", "while", "do", "for",
                 "to"};
    max_len    = max_token;
    requests   = 0;
    tokens     = 0;
    mismatches = 0;
    saturated  = 0;
    kinds_seen = '0;
    restart();
  endfunction

  function void restart();
    scan_state = SC_IDLE;
    lex_len    = 0;
    kw_live    = '1;
  endfunction

  function bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function void add_token(logic [5:0] kind, int unsigned len, logic [7:0] bad);
    token_t t;
    t.kind = kind;
    t.len  = (len > 127) ? 7'd127 : 7'(len);
    t.bad  = bad;
    t.last = 1'b0;
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  function void bump();
    if (lex_len < max_len) lex_len++;
  endfunction

  function void match_kw(logic [7:0] c);
    for (int k = 0; k < 17; k++) begin
      if (lex_len >= kw_words[k].len() || kw_words[k][lex_len] != c) kw_live[k] = 1'b0;
    end
  endfunction

  function void flush_ident();
    logic [5:0] kind;
    kind = K_IDENT;
    for (int k = 16; k >= 0; k--) begin
      if (kw_live[k] && lex_len == kw_words[k].len()) kind = K_KW0 + 6'(k);
    end
    add_token(kind, lex_len, 8'h00);
  endfunction

  function void scan_fresh(logic [7:0] c);
    restart();
    case (c) inside
      CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_NUL: ;
      CH_LT:     scan_state = SC_LESS;
      CH_GT:     scan_state = SC_GREATER;
      CH_COLON:  scan_state = SC_COLON;
      CH_LBRACE: begin
        scan_state = SC_COMMENT;
        lex_len    = 1;
      end
      CH_RBRACE: add_token(K_RBRACE, 1, 8'h00);
      CH_EQ:     add_token(K_EQ, 1, 8'h00);
      ";":       add_token(K_SEMI, 1, 8'h00);
      CH_DOT:    add_token(K_DOT, 1, 8'h00);
      "+":       add_token(K_PLUS, 1, 8'h00);
      "-":       add_token(K_MINUS, 1, 8'h00);
      "/":       add_token(K_SLASH, 1, 8'h00);
      "*":       add_token(K_STAR, 1, 8'h00);
      "(":       add_token(K_LPAREN, 1, 8'h00);
      ")":       add_token(K_RPAREN, 1, 8'h00);
      default: begin
        if (is_digit(c)) begin
          scan_state = SC_INT;
          lex_len    = 1;
        end else if (is_letter(c)) begin
          scan_state = SC_IDENT;
          match_kw(c);
          lex_len    = 1;
        end else begin
          add_token(K_BADCH, 1, c);
        end
      end
    endcase
  endfunction

  function void note_request(logic [7:0] c, logic eoi);
    int unsigned n0;
    n0 = expected_tokens.size();
    requests++;
    if (eoi) begin
      case (scan_state)
        SC_IDENT:   flush_ident();
        SC_INT:     add_token(K_INT, lex_len, 8'h00);
        SC_REAL:    add_token(K_REAL, lex_len, 8'h00);
        SC_LESS:    add_token(K_LT, 1, 8'h00);
        SC_GREATER: add_token(K_GT, 1, 8'h00);
        SC_COLON:   add_token(K_COLON, 1, 8'h00);
        SC_COMMENT: add_token(K_BADCOM, lex_len, 8'h00);
        default: ;
      endcase
      restart();
    end else begin
      case (scan_state)
        SC_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            match_kw(c);
            bump();
          end else begin
            flush_ident();
            scan_fresh(c);
          end
        end
        SC_INT: begin
          if (is_digit(c)) begin
            bump();
          end else if (c == CH_DOT) begin
            bump();
            scan_state = SC_REAL;
          end else begin
            add_token(K_INT, lex_len, 8'h00);
            scan_fresh(c);
          end
        end
        SC_REAL: begin
          if (is_digit(c)) begin
            bump();
          end else begin
            add_token(K_REAL, lex_len, 8'h00);
            scan_fresh(c);
          end
        end
        SC_LESS: begin
          if (c == CH_EQ) begin
            add_token(K_LE, 2, 8'h00);
            restart();
          end else if (c == CH_GT) begin
            add_token(K_NE, 2, 8'h00);
            restart();
          end else begin
            add_token(K_LT, 1, 8'h00);
            scan_fresh(c);
          end
        end
        SC_GREATER: begin
          if (c == CH_EQ) begin
            add_token(K_GE, 2, 8'h00);
            restart();
          end else begin
            add_token(K_GT, 1, 8'h00);
            scan_fresh(c);
          end
        end
        SC_COLON: begin
          if (c == CH_EQ) begin
            add_token(K_ASSIGN, 2, 8'h00);
            restart();
          end else begin
            add_token(K_COLON, 1, 8'h00);
            scan_fresh(c);
          end
        end
        SC_COMMENT: begin
          if (c == CH_LF) begin
            add_token(K_BADCOM, lex_len, 8'h00);
            restart();
          end else if (c == CH_RBRACE) begin
            restart();
          end else begin
            bump();
          end
        end
        default: scan_fresh(c);
      endcase
    end
    if (expected_tokens.size() > n0) begin
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    end
  endfunction

  function void check_token(token_t got);
    token_t want;
    tokens++;
    kinds_seen[got.kind] = 1'b1;
    if (got.len == 7'(max_len)) saturated++;
    if (expected_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("token %0d: none expected, got kind %0d len %0d bad %02h last %0b",
                 tokens, got.kind, got.len, got.bad, got.last);
      return;
    end
    want = expected_tokens.pop_front();
    if (got.kind !== want.kind || got.len !== want.len || got.bad !== want.bad ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $write("token %0d: expected kind %0d len %0d bad %02h last %0b, ",
               tokens, want.kind, want.len, want.bad, want.last);
        $display("got kind %0d len %0d bad %02h last %0b",
                 got.kind, got.len, got.bad, got.last);
      end
    end
  endfunction
endclass

module tb_pascal_subset_lexer;

  localparam int unsigned LEX_MAX        = 64;
  localparam int unsigned RANDOM_ITEMS   = 1500;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic [7:0] char_code_i    = 8'h00;
  logic       end_of_input_i = 1'b0;
  logic       out_stall_i    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [5:0] token_kind_o;
  logic [6:0] lexeme_length_o;
  logic [7:0] bad_char_o;
  logic       last_of_run_o;

  logic        hold_req = 1'b0;
  int unsigned burst_left = 0;
  int unsigned random_items = 0;
  req_t        text_q[$];
  lex_scoreboard sb = new(LEX_MAX);

  pascal_subset_lexer #(.MAX_TOKEN(LEX_MAX)) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .lexeme_length_o(lexeme_length_o),
    .bad_char_o     (bad_char_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    token_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(char_code_i, end_of_input_i);
      if (out_valid_o && !out_stall_i) begin
        got.kind = token_kind_o;
        got.len  = lexeme_length_o;
        got.bad  = bad_char_o;
        got.last = last_of_run_o;
        sb.check_token(got);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no request or token moved for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stall stretches, plus one long hold when asked
  initial begin
    int unsigned r;
    int unsigned span;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          out_stall_i <= 1'b0;
          span = $urandom_range(1, 4);
        end else if (r < 70) begin
          out_stall_i <= 1'b1;
          span = $urandom_range(1, 3);
        end else if (r < 78) begin
          out_stall_i <= 1'b1;
          span = $urandom_range(10, 40);
        end else begin
          out_stall_i <= 1'b0;
          span = $urandom_range(20, 80);
        end
        repeat (span) @(posedge clk_i);
      end
    end
  end

  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_request(input logic [7:0] c, input logic eoi);
    int unsigned gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_code_i    <= eoi ? 8'($urandom) : c;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic void add_char(logic [7:0] c);
    req_t r;
    r.c   = c;
    r.eoi = 1'b0;
    text_q.insert(text_q.size(), r);
  endfunction

  function automatic void add_end();
    req_t r;
    r.c   = CH_NUL;
    r.eoi = 1'b1;
    text_q.insert(text_q.size(), r);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_content();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF || c == CH_RBRACE);
    return c;
  endfunction

  task automatic send_queued();
    req_t r;
    while (text_q.size() > 0) begin
      r = text_q.pop_front();
      send_request(r.c, r.eoi);
    end
  endtask

  task automatic wait_for_tokens();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_fragment();
    string       ops[7];
    string       syms;
    string       word;
    int unsigned r;
    int unsigned n;
    int unsigned mut;
    ops  = '{":=", "<>", ">=", "<=", "<", ">", ":"};
    syms = "}=;.+-/*()";
    r = $urandom_range(0, 99);
    if (r < 20) begin
      word = sb.kw_words[$urandom_range(0, 16)];
      mut  = $urandom_range(0, 7);
      if (mut == 0) word = word.substr(0, word.len() - 2);
      if (mut == 1) word[0] = word[0] - 8'h20;
      add_text(word);
      if (mut == 2) add_char(rand_letter());
      if (mut == 3) add_char(rand_digit());
    end else if (r < 32) begin
      add_char(rand_letter());
      n = ($urandom_range(0, 32) == 0) ? $urandom_range(60, 75) : $urandom_range(0, 7);
      repeat (n) add_char($urandom_range(0, 1) ? rand_letter() : rand_digit());
    end else if (r < 44) begin
      n = ($urandom_range(0, 32) == 0) ? $urandom_range(62, 75) : $urandom_range(1, 6);
      repeat (n) add_char(rand_digit());
    end else if (r < 52) begin
      repeat ($urandom_range(1, 4)) add_char(rand_digit());
      add_char(CH_DOT);
      repeat ($urandom_range(0, 4)) add_char(rand_digit());
    end else if (r < 64) begin
      add_text(ops[$urandom_range(0, 6)]);
    end else if (r < 76) begin
      add_char(syms[$urandom_range(0, 9)]);
    end else if (r < 84) begin
      add_char(CH_LBRACE);
      n = ($urandom_range(0, 32) == 0) ? $urandom_range(62, 72) : $urandom_range(0, 8);
      repeat (n) add_char(rand_content());
      add_char(CH_RBRACE);
    end else if (r < 89) begin
      add_char(CH_LBRACE);
      n = ($urandom_range(0, 20) == 0) ? $urandom_range(62, 72) : $urandom_range(0, 8);
      repeat (n) add_char(rand_content());
      if ($urandom_range(0, 3) == 0) add_end();
      else add_char(CH_LF);
    end else if (r < 95) begin
      add_char(8'($urandom_range(0, 255)));
    end else begin
      add_end();
    end
    case ($urandom_range(0, 9)) inside
      0: add_char(CH_SPACE);
      1: add_char(CH_TAB);
      2: add_char(CH_LF);
      3: add_char(CH_CR);
      4: add_char(CH_NUL);
      5, 6: add_char(CH_SPACE);
      default: ;
    endcase
    random_items += text_q.size();
    send_queued();
  endtask

  initial begin
    bit hold_done;
    bit paused;
    hold_done = 1'b0;
    paused    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // lone operators, assign, real after dot, symbol then comment, bad bytes,
    // open comments at line feed and at end mark, end mark in idle
    add_text("<a:=12.;+{");
    add_char(CH_NUL);
    add_char(CH_RBRACE);
    add_char(8'hFF);
    add_char(8'h80);
    add_text("{q");
    add_char(CH_LF);
    add_text(">=:");
    add_end();
    add_end();
    add_text("{x");
    add_end();
    send_queued();
    wait_for_tokens();

    while (random_items < RANDOM_ITEMS) begin
      if (!hold_done && random_items >= RANDOM_ITEMS / 3) begin
        hold_done  = 1'b1;
        hold_req  <= 1'b1;
        burst_left = 60;
      end
      if (!paused && random_items >= 2 * RANDOM_ITEMS / 3) begin
        paused = 1'b1;
        wait_for_tokens();
      end
      send_fragment();
    end
    wait_for_tokens();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Scanned %0d characters and end marks into %0d tokens, %0d mismatched.",
             sb.requests, sb.tokens, sb.mismatches);
    $display("Saw %0d of 39 token kinds; %0d tokens hit the length limit; %0d still pending.",
             $countones(sb.kinds_seen), sb.saturated, sb.expected_tokens.size());
    if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== pascal_subset_lexer.f =====
design/pslex_pkg.sv
design/pslex_front.sv
design/pslex_queue.sv
design/pslex_back.sv
design/pascal_subset_lexer.sv
dv/tb_pascal_subset_lexer.sv
